[hw/rtl/gfrma_pkg.sv]
// ============================================================================
// gfrma_pkg
// Shared types and constants for the GF(2^8) region multiply-add engine.
// ============================================================================
`default_nettype none

package gfrma_pkg;

    localparam int BYTE_SLOTS = 8;                 // byte positions in a word
    localparam int LANES      = 8;                 // slots served by a multiplier lane
    localparam int DATA_W     = 8 * BYTE_SLOTS;
    localparam int COUNT_W    = 4;

    localparam logic [8:0] GF_POLY     = 9'o435;   // x^8+x^4+x^3+x^2+1
    localparam logic [7:0] GF_POLY_LOW = GF_POLY[7:0];

    localparam int S_TDATA_W = ((2 * DATA_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic {
        ACT_MUL_ADD = 1'b0,
        ACT_MUL     = 1'b1
    } t_action;

    typedef struct packed {
        logic                 valid;
        logic [COUNT_W-1:0]   lanes;
    } t_word_ctl;

endpackage

`default_nettype wire

[hw/rtl/gfrma_lane.sv]
// ============================================================================
// gfrma_lane
// One byte lane: GF(2^8) shift-and-reduce multiply, then add or pass through.
// ============================================================================
`default_nettype none

module gfrma_lane
    import gfrma_pkg::*;
(
    input  wire logic [7:0] i_src,
    input  wire logic [7:0] i_dst,
    input  wire logic [7:0] i_mult,
    input  wire t_action    i_action,
    input  wire logic       i_active,
    output logic [7:0]      o_result
);

    logic [7:0] prod;

    always_comb begin
        logic [7:0] x;
        logic [7:0] acc;
        x   = i_src;
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (i_mult[k]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
        end
        prod = acc;
    end

    always_comb begin
        unique case (i_action)
            ACT_MUL:     o_result = i_active ? prod : i_src;
            ACT_MUL_ADD: o_result = i_active ? (i_dst ^ prod) : i_dst;
            default:     o_result = i_dst;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/gfrma_merge.sv]
// ============================================================================
// gfrma_merge
// Gathers the lane bytes into one word and holds it in the output register.
// ============================================================================
`default_nettype none

module gfrma_merge
    import gfrma_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_word_ctl             i_ctl,
    input  wire logic [7:0]            i_lane_bytes [BYTE_SLOTS],
    output logic                       o_ready,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata  // result_bytes, result_lanes
);

    logic               r_valid;
    logic [DATA_W-1:0]  r_bytes;
    logic [COUNT_W-1:0] r_lanes;
    logic [DATA_W-1:0]  n_bytes;
    logic               load;

    always_comb begin
        for (int i = 0; i < BYTE_SLOTS; i++) begin
            n_bytes[8*i +: 8] = i_lane_bytes[i];
        end
    end

    assign o_ready = !r_valid || m_axis_tready;
    assign load    = i_ctl.valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_bytes;
            r_lanes <= i_ctl.lanes;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, r_lanes, r_bytes};

endmodule

`default_nettype wire

[hw/rtl/gf256_region_multiply_add_top.sv]
// ============================================================================
// gf256_region_multiply_add_top
// GF(2^8) region multiply / multiply-add over eight byte lanes per word.
//
// Channels: s_axis carries one input word (src bytes, dst bytes, valid lane
// count in tdata, action in tuser); m_axis returns the result bytes and the
// echoed lane count. i_cfg_we/i_cfg_wdata load the GF(256) multiplier; write
// it only while no word is in flight.
// Output valid: m_axis_tvalid is registered and rises in the cycle after s_axis acceptance.
// Throughput: 1 word per cycle; all lanes multiply in parallel and the output
// register is the only stage, so a new word is taken whenever the output
// register is empty or is being drained in the same cycle.
// Stall: when m_axis_tready is low with a word held, s_axis_tready drops and
// the held word stays stable.
// Reset: synchronous, active low; clears the output valid and sets the
// multiplier to zero.
// ============================================================================
`default_nettype none

module gf256_region_multiply_add_top
    import gfrma_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [7:0]            i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // src_bytes, dst_bytes, valid_lanes
    input  wire logic [0:0]            s_axis_tuser,  // action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata   // result_bytes, result_lanes
);

    logic [7:0]         r_mult;
    logic [DATA_W-1:0]  src;
    logic [DATA_W-1:0]  dst;
    logic [COUNT_W-1:0] count;
    t_action            action;
    logic [7:0]         lane_bytes [BYTE_SLOTS];
    t_word_ctl          ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= 8'h00;
        end else if (i_cfg_we) begin
            r_mult <= i_cfg_wdata;
        end
    end

    assign src    = s_axis_tdata[DATA_W-1:0];
    assign dst    = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign count  = s_axis_tdata[2*DATA_W +: COUNT_W];
    assign action = t_action'(s_axis_tuser[0]);

    for (genvar i = 0; i < BYTE_SLOTS; i++) begin : g_slot
        if (i < LANES) begin : g_lane
            logic active;
            assign active = ({1'b0, count} > (COUNT_W+1)'(i));
            gfrma_lane u_lane (
                .i_src    (src[8*i +: 8]),
                .i_dst    (dst[8*i +: 8]),
                .i_mult   (r_mult),
                .i_action (action),
                .i_active (active),
                .o_result (lane_bytes[i])
            );
        end else begin : g_pass
            assign lane_bytes[i] = (action == ACT_MUL) ? src[8*i +: 8] : dst[8*i +: 8];
        end
    end

    assign ctl.valid = s_axis_tvalid;
    assign ctl.lanes = count;

    gfrma_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_lane_bytes  (lane_bytes),
        .o_ready       (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[test/testbench.sv]
// ============================================================================
// testbench
// Checks gf256_region_multiply_add_top against a built-in GF(2^8) predictor.
// Directed words cover multipliers zero, one and 0xff, both actions,
// all-zero and all-one lanes, and lane counts 0, 1, 3, 7, 8, 9 and 15.
// Random phases then run across several multipliers with random stalls on
// both channels, plus one phase with no stalls. Each accepted input word is
// predicted at acceptance and checked field by field against the next
// output word.
// ============================================================================
`default_nettype none

module testbench;
    import gfrma_pkg::*;

    localparam int PAD_W      = S_TDATA_W - 2 * DATA_W - COUNT_W;
    localparam int STALL_PCT  = 29;
    localparam int STALL_MAX  = 2000;
    localparam int PHASE_SIZE = 200;
    localparam int PHASES     = 8;

    typedef struct {
        t_action              act;
        logic [DATA_W-1:0]    src;
        logic [DATA_W-1:0]    dst;
        logic [COUNT_W-1:0]   lanes;
    } t_region_word;

    typedef struct {
        logic [DATA_W-1:0]    bytes;
        logic [COUNT_W-1:0]   lanes;
    } t_region_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [7:0]            i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // src_bytes, dst_bytes, valid_lanes, zero pad
    logic [0:0]            s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // result_bytes, result_lanes, zero pad

    t_region_word    word_queue[$];
    t_region_word    word_in_flight;
    t_region_result  expected_results[$];
    logic [7:0]      gf_multiplier;
    logic            steady_flow;
    logic            word_taken;
    int              mismatch_count;
    int              stall_cycles;

    gf256_region_multiply_add_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shift-and-reduce product in GF(2^8)
    function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= x[7:0];
            x = x << 1;
            if (x[8]) x ^= GF_POLY;
        end
        return acc;
    endfunction

    function automatic t_region_result region_multiply_add(t_region_word w);
        t_region_result r;
        int             active;
        logic [7:0]     s;
        logic [7:0]     d;
        logic [7:0]     p;
        active = (w.lanes > LANES) ? LANES : int'(w.lanes);
        for (int i = 0; i < BYTE_SLOTS; i++) begin
            s = w.src[8*i +: 8];
            d = w.dst[8*i +: 8];
            if (i < active) begin
                p = gf_product(s, gf_multiplier);
                r.bytes[8*i +: 8] = (w.act == ACT_MUL) ? p : (d ^ p);
            end else begin
                r.bytes[8*i +: 8] = (w.act == ACT_MUL) ? s : d;
            end
        end
        r.lanes = w.lanes;
        return r;
    endfunction

    // driver: source side and sink ready change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
            if (!s_axis_tvalid || word_taken) begin
                if (word_queue.size() > 0 &&
                    (steady_flow || $urandom_range(99) >= STALL_PCT)) begin
                    word_in_flight = word_queue.pop_front();
                    s_axis_tdata   <= {{PAD_W{1'b0}}, word_in_flight.lanes,
                                       word_in_flight.dst, word_in_flight.src};
                    s_axis_tuser   <= word_in_flight.act;
                    s_axis_tvalid  <= 1'b1;
                end else begin
                    s_axis_tvalid  <= 1'b0;
                end
            end
        end
    end

    // monitor: prediction at input acceptance, check at output acceptance
    always @(posedge i_clk) begin
        t_region_result want;
        t_region_word   seen;
        logic [DATA_W-1:0]  got_bytes;
        logic [COUNT_W-1:0] got_lanes;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                word_taken  = 1'b1;
                seen.act    = t_action'(s_axis_tuser[0]);
                seen.src    = s_axis_tdata[DATA_W-1:0];
                seen.dst    = s_axis_tdata[2*DATA_W-1:DATA_W];
                seen.lanes  = s_axis_tdata[2*DATA_W +: COUNT_W];
                expected_results.push_back(region_multiply_add(seen));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_bytes = m_axis_tdata[DATA_W-1:0];
                got_lanes = m_axis_tdata[DATA_W +: COUNT_W];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: bytes %h lanes %0d",
                                 got_bytes, got_lanes);
                end else begin
                    want = expected_results.pop_front();
                    if (got_bytes !== want.bytes || got_lanes !== want.lanes) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: bytes exp %h got %h, lanes exp %0d got %0d",
                                     want.bytes, got_bytes, want.lanes, got_lanes);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (expected_results.size() == 0 && !s_axis_tvalid))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("timeout: no word moved for %0d cycles", STALL_MAX);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic push_word(t_action act, logic [DATA_W-1:0] src,
                             logic [DATA_W-1:0] dst, logic [COUNT_W-1:0] lanes);
        t_region_word w;
        w.act   = act;
        w.src   = src;
        w.dst   = dst;
        w.lanes = lanes;
        word_queue.push_back(w);
    endtask

    function automatic logic [DATA_W-1:0] random_bytes();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {8{8'($urandom_range(255))}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_random();
        logic [COUNT_W-1:0] lanes;
        if ($urandom_range(9) < 8)
            lanes = COUNT_W'($urandom_range(LANES, 1));
        else
            lanes = COUNT_W'($urandom_range(2**COUNT_W - 1));
        push_word(t_action'($urandom_range(1)), random_bytes(), random_bytes(), lanes);
    endtask

    task automatic wait_idle();
        while (word_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_multiplier(logic [7:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= value;
        gf_multiplier = value;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    initial begin
        logic [7:0] m;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        gf_multiplier  = '0;
        steady_flow    = 1'b0;
        word_taken     = 1'b0;
        mismatch_count = 0;
        stall_cycles   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // multiplier zero straight out of reset
        push_word(ACT_MUL_ADD, {$urandom, $urandom}, '1, 4'd8);
        push_word(ACT_MUL, '1, {$urandom, $urandom}, 4'd8);
        push_word(ACT_MUL_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd0);

        write_multiplier(8'h01);
        push_word(ACT_MUL_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd8);
        push_word(ACT_MUL, {$urandom, $urandom}, {$urandom, $urandom}, 4'd8);
        push_word(ACT_MUL, {$urandom, $urandom}, {$urandom, $urandom}, 4'd3);

        write_multiplier(8'hff);
        push_word(ACT_MUL_ADD, '1, '1, 4'd8);
        push_word(ACT_MUL, '1, '0, 4'd8);
        push_word(ACT_MUL_ADD, '0, '1, 4'd8);
        push_word(ACT_MUL, 64'h8040201008040201, '0, 4'd8);
        push_word(ACT_MUL, {$urandom, $urandom}, {$urandom, $urandom}, 4'd1);
        push_word(ACT_MUL_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd7);
        push_word(ACT_MUL, {$urandom, $urandom}, {$urandom, $urandom}, 4'd9);
        push_word(ACT_MUL_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd15);
        push_word(ACT_MUL, '1, '1, 4'd0);
        push_word(ACT_MUL_ADD, '0, '0, 4'd15);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       m = 8'h02;
                1:       m = 8'h80;
                3:       m = 8'hff;
                4:       m = 8'h00;
                5:       m = 8'h01;
                default: m = 8'($urandom_range(255));
            endcase
            write_multiplier(m);
            steady_flow = (ph == 2);
            for (int n = 0; n < PHASE_SIZE; n++)
                push_random();
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/gfrma_pkg.sv
hw/rtl/gfrma_lane.sv
hw/rtl/gfrma_merge.sv
hw/rtl/gf256_region_multiply_add_top.sv
test/testbench.sv
